// File: hw/rtl/chunked_merge_sorter_defines.svh
// Assertion macros used by the checker file of the chunked merge sorter.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CHUNKED_MERGE_SORTER_DEFINES_SVH
`define CHUNKED_MERGE_SORTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`define CMS_ASSERT_TWO(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/cms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cms_pkg;

  // Transaction kinds on the input channel.
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_SORT = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Control of the buffer pair: write enable, write buffer and read buffer.
  typedef struct packed {
    logic wr_en;
    logic wr_buf;
    logic rd_buf;
  } mem_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/cms_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Two word buffers, one write port and two registered read ports.
module cms_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic              clk,
  input  wire cms_pkg::mem_ctrl_t ctrl,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [31:0]       wdata,
  input  wire logic [AW-1:0]     raddr_a,
  input  wire logic [AW-1:0]     raddr_b,
  output logic [31:0]            rdata_a,
  output logic [31:0]            rdata_b
);

  logic [31:0] mem0 [DEPTH];
  logic [31:0] mem1 [DEPTH];
  logic [31:0] r0a, r0b, r1a, r1b;
  logic        rd_sel;

  // Buffer zero.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && !ctrl.wr_buf) begin
      mem0[waddr] <= wdata;
    end
    r0a <= mem0[raddr_a];
    r0b <= mem0[raddr_b];
  end

  // Buffer one.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && ctrl.wr_buf) begin
      mem1[waddr] <= wdata;
    end
    r1a <= mem1[raddr_a];
    r1b <= mem1[raddr_b];
  end

  // The buffer choice is registered together with the read data.
  always_ff @(posedge clk) begin
    rd_sel <= ctrl.rd_buf;
  end

  assign rdata_a = rd_sel ? r1a : r0a;
  assign rdata_b = rd_sel ? r1b : r0b;

endmodule

`default_nettype wire

// File: hw/rtl/chunked_merge_sorter.sv
`timescale 1ns / 1ps
`default_nettype none

// Chunked merge sorter.
// Input channel (in_valid, in_stall) carries kind, index and value. A load
// writes value at index, a read returns the word at index, a sort puts each
// chunk of CHUNK_DEPTH words into ascending signed order, stable, on its own.
// Every transaction gives exactly one result on the output channel
// (out_valid, out_stall) with read_value and read_valid.
// A load result shows in the cycle after acceptance; a read result passes
// through the registered buffer read and the read wait state. A sort
// merges run pairs in each chunk, ceil(log2(CHUNK_DEPTH)) passes per chunk,
// one word at a time through the single comparator and the one write port.
// A load is taken only while idle with the output free; the sort result follows
// the last pass. The block accepts nothing while a read or a sort runs.
// Reset clears the sequencer and out_valid; the buffers hold
// nothing defined until loaded. A stalled result holds, and in_stall stays
// high until it is taken.
module chunked_merge_sorter #(
  parameter int CHUNK_DEPTH = 512,
  parameter int NUM_CHUNKS  = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [10:0] index,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      read_value,
  output logic             read_valid
);

  localparam int STORE = CHUNK_DEPTH * NUM_CHUNKS;
  localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int XW    = $clog2(STORE + 1) + 2;
  localparam logic [XW-1:0] STORE_X = XW'(STORE);
  localparam logic [XW-1:0] CHUNK_X = XW'(CHUNK_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDW   = 3'd1;
  localparam logic [2:0] ST_CHUNK = 3'd2;
  localparam logic [2:0] ST_SEG   = 3'd3;
  localparam logic [2:0] ST_FETCH = 3'd4;
  localparam logic [2:0] ST_PICK  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]    state;
  logic          cur;
  logic          src;
  logic          rd_oob;
  logic [XW-1:0] base, lo, width, mid, hi, a, b, k;

  logic               accept, out_free, idx_ok, out_set;
  logic [XW-1:0]      chunk_end, lo_w, mid_c, mid_w, hi_c, k_inc;
  logic               take_a;
  cms_pkg::mem_ctrl_t ctrl;
  logic [AW-1:0]      waddr, raddr_a, raddr_b;
  logic [31:0]        wdata, rdata_a, rdata_b;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign idx_ok   = {{(32-11){1'b0}}, index} < 32'(STORE);

  // A new result is loaded into the output register this cycle.
  assign out_set = ((state == ST_IDLE) && accept && (kind != cms_pkg::KIND_READ) &&
                    (kind != cms_pkg::KIND_SORT)) ||
                   (state == ST_RDW) ||
                   ((state == ST_DONE) && out_free);

  // Segment bounds for the next run pair.
  assign chunk_end = base + CHUNK_X;
  assign lo_w      = lo + width;
  assign mid_c     = (lo_w < chunk_end) ? lo_w : chunk_end;
  assign mid_w     = mid_c + width;
  assign hi_c      = (mid_w < chunk_end) ? mid_w : chunk_end;
  assign k_inc     = k + XW'(1);

  // Comparator: the left run wins ties.
  assign take_a = (a < mid) && ((b >= hi) || ($signed(rdata_a) <= $signed(rdata_b)));

  // Buffer port control.
  always_comb begin
    ctrl.wr_en  = 1'b0;
    ctrl.wr_buf = cur;
    ctrl.rd_buf = src;
    waddr       = index[AW-1:0];
    wdata       = value;
    raddr_a     = a[AW-1:0];
    raddr_b     = b[AW-1:0];
    if (state == ST_IDLE) begin
      ctrl.rd_buf = cur;
      raddr_a     = index[AW-1:0];
      ctrl.wr_en  = accept && (kind == cms_pkg::KIND_LOAD) && idx_ok;
    end else if (state == ST_PICK) begin
      ctrl.wr_en  = 1'b1;
      ctrl.wr_buf = !src;
      waddr       = k[AW-1:0];
      wdata       = take_a ? rdata_a : rdata_b;
    end
  end

  cms_mem #(.DEPTH(STORE), .AW(AW)) u_mem (
    .clk     (clk),
    .ctrl    (ctrl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur       <= 1'b0;
      src       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_set) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (kind == cms_pkg::KIND_READ) begin
              rd_oob <= !idx_ok;
              state  <= ST_RDW;
            end else if (kind == cms_pkg::KIND_SORT) begin
              base  <= '0;
              state <= ST_CHUNK;
            end else begin
              out_valid  <= 1'b1;
              read_value <= '0;
              read_valid <= 1'b0;
            end
          end
        end
        ST_RDW: begin
          out_valid  <= 1'b1;
          read_value <= rd_oob ? 32'd0 : rdata_a;
          read_valid <= 1'b1;
          state      <= ST_IDLE;
        end
        ST_CHUNK: begin
          lo    <= base;
          width <= XW'(1);
          src   <= cur;
          state <= ST_SEG;
        end
        ST_SEG: begin
          if (width >= CHUNK_X) begin
            if (chunk_end >= STORE_X) begin
              cur   <= src;
              state <= ST_DONE;
            end else begin
              base  <= chunk_end;
              state <= ST_CHUNK;
            end
          end else if (lo >= chunk_end) begin
            width <= width << 1;
            lo    <= base;
            src   <= !src;
          end else begin
            mid   <= mid_c;
            hi    <= hi_c;
            a     <= lo;
            b     <= mid_c;
            k     <= lo;
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_PICK;
        end
        ST_PICK: begin
          if (take_a) begin
            a <= a + XW'(1);
          end else begin
            b <= b + XW'(1);
          end
          k <= k_inc;
          if (k_inc == hi) begin
            lo    <= lo + (width << 1);
            state <= ST_SEG;
          end else begin
            state <= ST_FETCH;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            read_value <= '0;
            read_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cms_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "chunked_merge_sorter_defines.svh"

// Port-level checks of the chunked merge sorter.
module cms_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  kind,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] read_value,
  input wire logic        read_valid
);

  logic acc;
  assign acc = in_valid && !in_stall;

  `CMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `CMS_ASSERT_NOW(a_zero_nonread, out_valid && !read_valid, read_value == 32'd0)
  `CMS_ASSERT_NEXT(a_load_next, acc && (kind == cms_pkg::KIND_LOAD), out_valid && !read_valid)
  `CMS_ASSERT_TWO(a_read_two, acc && (kind == cms_pkg::KIND_READ), out_valid && read_valid)

endmodule

bind chunked_merge_sorter cms_checker u_cms_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .kind       (kind),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_value (read_value),
  .read_valid (read_valid)
);

`default_nettype wire
